[hdl/pee_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette editor package
// Shared sizes, opcodes, controller states and interface records for the
// palette entry editor.
// ----------------------------------------------------------------------------
package pee_pkg;

   // Store geometry
   localparam int ENTRIES = 64;
   localparam int COLUMNS = 16;
   localparam int ROWS    = 4;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int COLOR_W = 16;
   localparam int CHAN_W  = 5;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd31;

   // Bus widths: request and response data padded to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [3:0] {
      OP_LOAD       = 4'd0,
      OP_SNAPSHOT   = 4'd1,
      OP_DROP       = 4'd2,
      OP_MOVE       = 4'd3,
      OP_CHANNEL    = 4'd4,
      OP_BEGIN      = 4'd5,
      OP_END        = 4'd6,
      OP_ADJUST     = 4'd7,
      OP_REVERT_ONE = 4'd8,
      OP_REVERT_ALL = 4'd9,
      OP_READ       = 4'd10
   } opcode_type;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_ISSUE  = 7'b0000100,
      ST_MODIFY = 7'b0001000,
      ST_SWEEP  = 7'b0010000,
      ST_FETCH  = 7'b0100000,
      ST_LOOK   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [IDX_W-1:0]   entry_index;
      logic [COLOR_W-1:0] entry_value;
      logic signed [5:0]  step_x;
      logic signed [3:0]  step_y;
      logic signed [5:0]  amount;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   cursor_pos;
      logic [1:0]         active_channel;
      logic               edit_active;
      logic [COLOR_W-1:0] live_color;
      logic [COLOR_W-1:0] saved_color;
      logic               modified;
      logic               snapshot_valid;
   } result_type;

   // Port requests toward the two palette memories
   typedef struct packed {
      logic               live_we;
      logic               snap_we;
      logic [IDX_W-1:0]   waddr;
      logic [COLOR_W-1:0] wdata;
      logic [IDX_W-1:0]   raddr;
   } mem_req_type;

   // Residue modulo 3 by summing base-4 digits (4 is 1 mod 3)
   function automatic logic [1:0] mod3(input logic [6:0] v);
      logic [3:0] s1;
      logic [2:0] s2;
      s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[6]);
      s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
      if (s2 >= 3'd3) begin
         s2 = s2 - 3'd3;
      end
      return s2[1:0];
   endfunction

endpackage

[hdl/palette_entry_editor_core.sv]
`timescale 1ns / 1ps
// Register-only opcodes pass through idle, fetch and look; load, adjust and
// revert one add a read-modify-write of one entry (issue, modify), and snapshot
// and revert all add a copy sweep, one entry per cycle. Revert one and revert all
// act as register-only when no snapshot is held. One request at a time; the next
// is taken the cycle after the response is registered. Reset runs a clearing
// pass over both palettes with req_tready low.
// ----------------------------------------------------------------------------
// Palette entry editor core
// Live and snapshot palettes in two memories, the controller and the
// registered response stage.
// ----------------------------------------------------------------------------
module palette_entry_editor_core import pee_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // opcode[3:0], entry_index[9:4], entry_value[25:10], step_x[31:26],
   // step_y[35:32], amount[41:36], zero fill[47:42]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cursor_pos[5:0], active_channel[7:6], edit_active[8], live_color[24:9],
   // saved_color[40:25], modified[41], snapshot_valid[42], zero fill[47:43]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   req_type             req;
   result_type          res;
   mem_req_type         mem;
   logic                res_valid;
   logic                res_take;
   logic [COLOR_W-1:0]  live_rdata;
   logic [COLOR_W-1:0]  snap_rdata;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Unpack request
   always_comb begin
      req.opcode      = req_tdata[3:0];
      req.entry_index = req_tdata[9:4];
      req.entry_value = req_tdata[25:10];
      req.step_x      = req_tdata[31:26];
      req.step_y      = req_tdata[35:32];
      req.amount      = req_tdata[41:36];
   end

   pee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req        (req),
      .req_ready  (req_tready),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res),
      .mem        (mem),
      .live_rdata (live_rdata),
      .snap_rdata (snap_rdata)
   );

   pee_ram #(.WIDTH(COLOR_W), .DEPTH(ENTRIES)) u_live_ram (
      .clock (clock),
      .we    (mem.live_we),
      .waddr (mem.waddr),
      .wdata (mem.wdata),
      .raddr (mem.raddr),
      .rdata (live_rdata)
   );

   pee_ram #(.WIDTH(COLOR_W), .DEPTH(ENTRIES)) u_snap_ram (
      .clock (clock),
      .we    (mem.snap_we),
      .waddr (mem.waddr),
      .wdata (mem.wdata),
      .raddr (mem.raddr),
      .rdata (snap_rdata)
   );

   // Response slot is free when empty or draining this cycle
   assign res_take = !rsp_valid_ff || rsp_tready;

   // Hold response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_data_ff <= {5'b00000, res.snapshot_valid, res.modified, res.saved_color,
                         res.live_color, res.edit_active, res.active_channel,
                         res.cursor_pos};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hdl/pee_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette RAM
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module pee_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/pee_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette editor controller
// Sequencer for one request at a time: small state registers, the
// read-modify-write of single entries, bulk copy sweeps and the clearing pass.
// ----------------------------------------------------------------------------
module pee_ctrl import pee_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_type              req,
   output logic                 req_ready,
   output logic                 res_valid,
   input  logic                 res_take,
   output result_type           res,
   output mem_req_type          mem,
   input  logic [COLOR_W-1:0]   live_rdata,
   input  logic [COLOR_W-1:0]   snap_rdata
);

   state_type           state_ff, state_in;
   opcode_type          op_ff, op_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [COLOR_W-1:0]  val_ff, val_in;
   logic signed [5:0]   amt_ff, amt_in;
   logic [IDX_W-1:0]    cursor_ff, cursor_in;
   logic [1:0]          channel_ff, channel_in;
   logic                edit_ff, edit_in;
   logic                snap_ff, snap_in;
   logic [CNT_W-1:0]    diff_ff, diff_in;
   logic [CNT_W-1:0]    sweep_ff, sweep_in;

   logic [IDX_W-1:0]    target;
   logic [COLOR_W-1:0]  new_word;
   logic [CHAN_W-1:0]   field;
   logic signed [7:0]   field_sum;
   logic [CHAN_W-1:0]   field_new;
   logic [COL_W-1:0]    col_new;
   logic [ROW_W-1:0]    row_new;
   logic [6:0]          amt_bias;
   logic [2:0]          chan_sum;
   logic                old_diff;
   logic                new_diff;

   // Cursor move: power-of-two grid, wrap is the low bits of the sum
   assign col_new = COL_W'(cursor_ff[COL_W-1:0] + COL_W'(req.step_x));
   assign row_new = ROW_W'(cursor_ff[IDX_W-1:COL_W] + ROW_W'(req.step_y));

   // Channel rotate: bias amount by a multiple of 3 so it is non-negative
   assign amt_bias = 7'({req.amount[5], req.amount}) + 7'd33;
   assign chan_sum = 3'(channel_ff) + 3'(mod3(amt_bias));

   // Target entry of a single-entry update
   assign target = (op_ff == OP_LOAD) ? idx_ff : cursor_ff;

   // Clamped channel adjust of the word at the cursor
   always_comb begin
      case (channel_ff)
         2'd1:    field = live_rdata[9:5];
         2'd2:    field = live_rdata[14:10];
         default: field = live_rdata[4:0];
      endcase
      field_sum = 8'($signed({3'b000, field})) + 8'(amt_ff);
      if (field_sum[7]) begin
         field_new = '0;
      end else if (field_sum > 8'sd31) begin
         field_new = CHAN_MAX;
      end else begin
         field_new = field_sum[CHAN_W-1:0];
      end
   end

   // New word for the single-entry update
   always_comb begin
      new_word = live_rdata;
      case (op_ff)
         OP_LOAD:       new_word = val_ff;
         OP_REVERT_ONE: new_word = snap_rdata;
         OP_ADJUST: begin
            case (channel_ff)
               2'd1:    new_word[9:5]   = field_new;
               2'd2:    new_word[14:10] = field_new;
               default: new_word[4:0]   = field_new;
            endcase
         end
         default:       new_word = live_rdata;
      endcase
   end

   assign old_diff = (live_rdata != snap_rdata);
   assign new_diff = (new_word != snap_rdata);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      amt_in     = amt_ff;
      cursor_in  = cursor_ff;
      channel_in = channel_ff;
      edit_in    = edit_ff;
      snap_in    = snap_ff;
      diff_in    = diff_ff;
      sweep_in   = sweep_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      mem        = '0;
      mem.raddr  = cursor_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem.live_we = 1'b1;
            mem.snap_we = 1'b1;
            mem.waddr   = sweep_ff[IDX_W-1:0];
            sweep_in    = sweep_ff + CNT_W'(1);
            if (sweep_ff[IDX_W-1:0] == IDX_W'(ENTRIES - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = opcode_type'(req.opcode);
               idx_in   = req.entry_index;
               val_in   = req.entry_value;
               amt_in   = req.amount;
               state_in = ST_FETCH;
               case (opcode_type'(req.opcode))
                  OP_LOAD:    state_in = ST_ISSUE;
                  OP_ADJUST:  state_in = ST_ISSUE;
                  OP_SNAPSHOT: begin
                     snap_in  = 1'b1;
                     state_in = ST_SWEEP;
                  end
                  OP_DROP:    snap_in = 1'b0;
                  OP_MOVE:    cursor_in = {row_new, col_new};
                  OP_CHANNEL: begin
                     channel_in = (chan_sum >= 3'd3) ? 2'(chan_sum - 3'd3)
                                                     : chan_sum[1:0];
                  end
                  OP_BEGIN: begin
                     edit_in    = 1'b1;
                     channel_in = '0;
                  end
                  OP_END:     edit_in = 1'b0;
                  OP_REVERT_ONE: begin
                     if (snap_ff) begin
                        state_in = ST_ISSUE;
                     end
                  end
                  OP_REVERT_ALL: begin
                     if (snap_ff) begin
                        state_in = ST_SWEEP;
                     end
                  end
                  default:    state_in = ST_FETCH;
               endcase
            end
         end

         ST_ISSUE: begin
            mem.raddr = target;
            state_in  = ST_MODIFY;
         end

         ST_MODIFY: begin
            mem.raddr   = target;
            mem.live_we = 1'b1;
            mem.waddr   = target;
            mem.wdata   = new_word;
            diff_in     = diff_ff + CNT_W'(new_diff) - CNT_W'(old_diff);
            state_in    = ST_FETCH;
         end

         ST_SWEEP: begin
            // read entry n while writing entry n-1
            mem.raddr = sweep_ff[IDX_W-1:0];
            mem.waddr = IDX_W'(sweep_ff - CNT_W'(1));
            if (sweep_ff != '0) begin
               if (op_ff == OP_SNAPSHOT) begin
                  mem.snap_we = 1'b1;
                  mem.wdata   = live_rdata;
               end else begin
                  mem.live_we = 1'b1;
                  mem.wdata   = snap_rdata;
               end
            end
            sweep_in = sweep_ff + CNT_W'(1);
            if (sweep_ff == CNT_W'(ENTRIES)) begin
               sweep_in = '0;
               diff_in  = '0;
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            state_in = ST_LOOK;
         end

         ST_LOOK: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Result at the cursor
   always_comb begin
      res.cursor_pos     = cursor_ff;
      res.active_channel = channel_ff;
      res.edit_active    = edit_ff;
      res.live_color     = live_rdata;
      res.saved_color    = snap_rdata;
      res.modified       = snap_ff && (diff_ff != '0);
      res.snapshot_valid = snap_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cursor_ff  <= '0;
         channel_ff <= '0;
         edit_ff    <= 1'b0;
         snap_ff    <= 1'b0;
         diff_ff    <= '0;
         sweep_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         cursor_ff  <= cursor_in;
         channel_ff <= channel_in;
         edit_ff    <= edit_in;
         snap_ff    <= snap_in;
         diff_ff    <= diff_in;
         sweep_ff   <= sweep_in;
      end
   end

   // Request payload
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
      amt_ff <= amt_in;
   end

endmodule

[hdl/pee_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette editor port checker
// Concurrent checks on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
module pee_checker import pee_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Clearing pass blocks requests right after reset
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request accepted during clearing pass");

   // One request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted while busy");

   // Modified only with a snapshot held
   a_modified: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[41] && !rsp_tdata[42]))
      else $error("modified set without snapshot");

   // Channel stays in range
   a_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:6] != 2'd3)
      else $error("channel out of range");

endmodule

bind palette_entry_editor_core pee_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/palette_response_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette editor response checker
// Watches both streams of the palette entry editor. It keeps a shadow of the
// live and snapshot palettes, the cursor, the channel and the flags. It works
// out the status word that each accepted request should return, and compares
// every returned response field by field, oldest first.
// ----------------------------------------------------------------------------
module palette_response_checker import pee_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // opcode[3:0], entry_index[9:4], entry_value[25:10], step_x[31:26],
   // step_y[35:32], amount[41:36], zero fill[47:42]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cursor_pos[5:0], active_channel[7:6], edit_active[8], live_color[24:9],
   // saved_color[40:25], modified[41], snapshot_valid[42], zero fill[47:43]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatch_count,
   output int                    outstanding,
   output int                    compared
);

   localparam int CHANNELS    = 3;
   localparam int PRINT_LIMIT = 30;

   logic [COLOR_W-1:0] live_shadow [ENTRIES];
   logic [COLOR_W-1:0] snap_shadow [ENTRIES];
   int                 cursor_at;
   int                 channel_sel;
   logic               editing;
   logic               snap_held;
   result_type         predicted_status [$];

   // Apply one request to the shadow state and return the status it reports
   function automatic result_type edit_palette(input req_type r);
      int                 col;
      int                 row;
      int                 level;
      int                 shift;
      logic [COLOR_W-1:0] word;
      result_type         s;
      case (r.opcode)
         OP_LOAD: begin
            if (int'(r.entry_index) < ENTRIES) begin
               live_shadow[r.entry_index] = r.entry_value;
            end
         end
         OP_SNAPSHOT: begin
            for (int i = 0; i < ENTRIES; i++) begin
               snap_shadow[i] = live_shadow[i];
            end
            snap_held = 1'b1;
         end
         OP_DROP: begin
            snap_held = 1'b0;
         end
         OP_MOVE: begin
            // true modulo on both axes, any step size
            col = (cursor_at % COLUMNS) + int'(r.step_x);
            row = (cursor_at / COLUMNS) + int'(r.step_y);
            col = ((col % COLUMNS) + COLUMNS) % COLUMNS;
            row = ((row % ROWS) + ROWS) % ROWS;
            cursor_at = row * COLUMNS + col;
         end
         OP_CHANNEL: begin
            channel_sel = channel_sel + int'(r.amount);
            channel_sel = ((channel_sel % CHANNELS) + CHANNELS) % CHANNELS;
         end
         OP_BEGIN: begin
            editing     = 1'b1;
            channel_sel = 0;
         end
         OP_END: begin
            editing = 1'b0;
         end
         OP_ADJUST: begin
            // clamp the selected channel, keep every other bit
            if (cursor_at < ENTRIES) begin
               shift = (channel_sel % CHANNELS) * CHAN_W;
               word  = live_shadow[cursor_at];
               level = int'((word >> shift) & COLOR_W'(CHAN_MAX)) + int'(r.amount);
               if (level < 0) begin
                  level = 0;
               end else if (level > int'(CHAN_MAX)) begin
                  level = int'(CHAN_MAX);
               end
               word = (word & ~(COLOR_W'(CHAN_MAX) << shift)) | (COLOR_W'(level) << shift);
               live_shadow[cursor_at] = word;
            end
         end
         OP_REVERT_ONE: begin
            if (snap_held && cursor_at < ENTRIES) begin
               live_shadow[cursor_at] = snap_shadow[cursor_at];
            end
         end
         OP_REVERT_ALL: begin
            if (snap_held) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  live_shadow[i] = snap_shadow[i];
               end
            end
         end
         default: begin
            // read and the unused codes change nothing
         end
      endcase

      s.cursor_pos     = IDX_W'(cursor_at);
      s.active_channel = 2'(channel_sel);
      s.edit_active    = editing;
      s.live_color     = (cursor_at < ENTRIES) ? live_shadow[cursor_at] : '0;
      s.saved_color    = (cursor_at < ENTRIES) ? snap_shadow[cursor_at] : '0;
      s.snapshot_valid = snap_held;
      s.modified       = 1'b0;
      if (snap_held) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (live_shadow[i] != snap_shadow[i]) begin
               s.modified = 1'b1;
            end
         end
      end
      return s;
   endfunction

   // Print one line per mismatch (up to a limit) and count them all
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] response %0d: %s is 0x%0h, want 0x%0h",
                  $time, compared, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // Compare accepted responses, then predict accepted requests
   always @(posedge clock) begin
      result_type want;
      req_type    taken;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            live_shadow[i] = '0;
            snap_shadow[i] = '0;
         end
         cursor_at   = 0;
         channel_sel = 0;
         editing     = 1'b0;
         snap_held   = 1'b0;
         predicted_status.delete();
         mismatch_count = 0;
         outstanding    = 0;
         compared       = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_status.size() == 0) begin
               report_mismatch("response with nothing pending", 1, 0);
            end else begin
               want = predicted_status.pop_front();
               check_field("cursor_pos", rsp_tdata[5:0], want.cursor_pos);
               check_field("active_channel", rsp_tdata[7:6], want.active_channel);
               check_field("edit_active", rsp_tdata[8], want.edit_active);
               check_field("live_color", rsp_tdata[24:9], want.live_color);
               check_field("saved_color", rsp_tdata[40:25], want.saved_color);
               check_field("modified", rsp_tdata[41], want.modified);
               check_field("snapshot_valid", rsp_tdata[42], want.snapshot_valid);
               check_field("zero fill", rsp_tdata[47:43], 0);
               compared++;
            end
         end
         if (req_tvalid && req_tready) begin
            taken.opcode      = req_tdata[3:0];
            taken.entry_index = req_tdata[9:4];
            taken.entry_value = req_tdata[25:10];
            taken.step_x      = req_tdata[31:26];
            taken.step_y      = req_tdata[35:32];
            taken.amount      = req_tdata[41:36];
            predicted_status.push_back(edit_palette(taken));
         end
         outstanding = predicted_status.size();
      end
   end

endmodule

[tb/sv/tb_palette_entry_editor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette entry editor core testbench
// Drives a directed opening of palette edits, then random edit traffic in
// four pacing phases with idle requesters and stalling response sinks. A
// checker beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_palette_entry_editor_core;
   import pee_pkg::*;

   localparam logic [3:0] OP_UNUSED_FIRST  = 4'd11;
   localparam logic [3:0] OP_UNUSED_LAST   = 4'd15;
   localparam int         RESET_CYCLES     = 11;
   localparam int         RANDOM_PER_PHASE = 256;
   localparam int         PHASES           = 4;
   localparam int         DRAIN_CYCLES     = 80;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int compared;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sent          = 0;
   int directed      = 0;

   always #4 clock = ~clock;

   palette_entry_editor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   palette_response_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .compared       (compared)
   );

   // Stall the response sink at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Hold off at random, then present one request until it is taken
   task automatic send_request(input req_type r);
      logic [REQ_DATA_W-1:0] word;
      word        = '0;
      word[3:0]   = r.opcode;
      word[9:4]   = r.entry_index;
      word[25:10] = r.entry_value;
      word[31:26] = r.step_x;
      word[35:32] = r.step_y;
      word[41:36] = r.amount;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent++;
   endtask

   task automatic issue(input logic [3:0] op, input logic [IDX_W-1:0] idx,
                        input logic [COLOR_W-1:0] value, input logic signed [5:0] sx,
                        input logic signed [3:0] sy, input logic signed [5:0] amt);
      req_type r;
      r.opcode      = op;
      r.entry_index = idx;
      r.entry_value = value;
      r.step_x      = sx;
      r.step_y      = sy;
      r.amount      = amt;
      send_request(r);
      directed++;
   endtask

   // Edit-heavy random traffic: adjusts most often, then loads, moves and channel
   // steps, occasional snapshots and reverts, a little noise with unused codes
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick          = $urandom_range(0, 99);
      r.entry_index = IDX_W'($urandom);
      r.entry_value = COLOR_W'($urandom);
      r.step_x      = 6'($urandom);
      r.step_y      = 4'($urandom);
      if ($urandom_range(0, 1) == 0) begin
         r.amount = 6'(int'($urandom_range(0, 6)) - 3);
      end else begin
         r.amount = 6'($urandom);
      end
      if ($urandom_range(0, 1) == 0) begin
         r.step_x = 6'(int'($urandom_range(0, 4)) - 2);
      end
      if (pick < 14) begin
         r.opcode = OP_LOAD;
      end else if (pick < 17) begin
         r.opcode = OP_SNAPSHOT;
      end else if (pick < 19) begin
         r.opcode = OP_DROP;
      end else if (pick < 31) begin
         r.opcode = OP_MOVE;
      end else if (pick < 40) begin
         r.opcode = OP_CHANNEL;
      end else if (pick < 46) begin
         r.opcode = OP_BEGIN;
      end else if (pick < 50) begin
         r.opcode = OP_END;
      end else if (pick < 78) begin
         r.opcode = OP_ADJUST;
      end else if (pick < 84) begin
         r.opcode = OP_REVERT_ONE;
      end else if (pick < 87) begin
         r.opcode = OP_REVERT_ALL;
      end else if (pick < 95) begin
         r.opcode = OP_READ;
      end else begin
         r.opcode = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
      return r;
   endfunction

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: field extremes, clamping, wrapping, revert cases
      issue(OP_READ, 0, 16'h0000, 0, 0, 0);
      issue(OP_LOAD, 0, 16'hFFFF, 0, 0, 0);
      issue(OP_LOAD, 63, 16'h7FFF, 0, 0, 0);
      issue(OP_SNAPSHOT, 0, 0, 0, 0, 0);
      issue(OP_BEGIN, 0, 0, 0, 0, 0);
      issue(OP_ADJUST, 0, 0, 0, 0, 31);
      issue(OP_ADJUST, 0, 0, 0, 0, -32);
      issue(OP_CHANNEL, 0, 0, 0, 0, 31);
      issue(OP_CHANNEL, 0, 0, 0, 0, -32);
      issue(OP_ADJUST, 0, 0, 0, 0, 5);
      issue(OP_MOVE, 0, 0, -1, -1, 0);
      issue(OP_ADJUST, 0, 0, 0, 0, -1);
      issue(OP_MOVE, 0, 0, 31, 7, 0);
      issue(OP_MOVE, 0, 0, -32, -8, 0);
      issue(OP_MOVE, 0, 0, 1, 1, 0);
      issue(OP_REVERT_ONE, 0, 0, 0, 0, 0);
      issue(OP_END, 0, 0, 0, 0, 0);
      issue(OP_REVERT_ALL, 0, 0, 0, 0, 0);
      issue(OP_DROP, 0, 0, 0, 0, 0);
      // with no snapshot held: edits stick, reverts do nothing
      issue(OP_ADJUST, 0, 0, 0, 0, 3);
      issue(OP_REVERT_ONE, 0, 0, 0, 0, 0);
      issue(OP_REVERT_ALL, 0, 0, 0, 0, 0);
      for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++) begin
         issue(4'(code), 6'h3F, 16'hFFFF, -1, -1, -1);
      end

      // Random traffic over the pacing phases
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 67;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 67;
            end
            default: begin
               send_idle_pct = 29;
               stall_pct     = 29;
            end
         endcase
         repeat (RANDOM_PER_PHASE) send_request(random_request());
      end
      req_tvalid <= 1'b0;

      // Drain, then allow for any stray late response
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d directed, the rest random over %0d pacing phases.",
               sent, directed, PHASES);
      $display("%0d responses compared, %0d mismatches.", compared, mismatch_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("palette_entry_editor_core: match");
      end else begin
         $display("palette_entry_editor_core: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("Timed out with %0d responses still pending.", outstanding);
      $display("palette_entry_editor_core: mismatch");
      $finish;
   end

endmodule
